// ===== hw/rtl/uvad_pkg.sv =====
// ----------------------------------------------------------------------------
// uvad_pkg
// Shared constants and types for the UV attribute dedup block.
// ----------------------------------------------------------------------------
package uvad_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W       = 96;
    localparam int IDX_OUT_W   = 10;
    localparam int CNT_OUT_W   = 11;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_RES
    } t_state;

endpackage

// ===== hw/rtl/uv_attribute_dedup.sv =====
// ----------------------------------------------------------------------------
// uv_attribute_dedup
// Face-corner UV key dedup: linear scan of a key memory, compact indexing.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy low. The key is compared
// against the stored keys one memory read at a time: each key examined is
// read (S_RD) and then compared (S_CMP). The scan stops at the first match,
// so the keys examined number at most N, the keys stored before it, and all
// N when the key is new; an empty table skips the scan. The result appears
// for one cycle on o_strobe and must be taken then; busy stays high until
// that cycle is over. An item with last_of_mesh clears the table after its
// result, at no extra cost.
module uv_attribute_dedup (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [31:0]                   i_vertex_id,
    input  logic [31:0]                   i_u_bits,
    input  logic [31:0]                   i_v_bits,
    input  logic                          i_last_of_mesh,
    output logic                          o_strobe,
    output logic [uvad_pkg::IDX_OUT_W-1:0] o_unique_index,
    output logic                          o_is_new,
    output logic [31:0]                   o_u_out,
    output logic [31:0]                   o_v_out,
    output logic [uvad_pkg::CNT_OUT_W-1:0] o_unique_count,
    output logic                          o_table_full,
    output logic                          o_end_of_mesh
);
    import uvad_pkg::*;

    logic [KEY_W-1:0] r_mem [TABLE_DEPTH];

    t_state            r_state, n_state;
    logic [KEY_W-1:0]  r_key;
    logic              r_last;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_found, n_found;
    logic [KEY_W-1:0]  r_rdata;
    logic              accept;
    logic              room;
    logic              do_store;
    logic [CNT_W-1:0]  addr_next;
    logic [CNT_W-1:0]  count_after;

    assign accept    = start && (r_state == S_IDLE);
    assign room      = (r_count < CNT_W'(TABLE_DEPTH));
    assign do_store  = (r_state == S_RES) && !r_found && room;
    assign addr_next = CNT_W'(r_addr) + CNT_W'(1);
    assign count_after = do_store ? (r_count + CNT_W'(1)) : r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr  <= n_addr;
        r_found <= n_found;
        if (accept) begin
            r_key  <= {i_vertex_id, i_u_bits, i_v_bits};
            r_last <= i_last_of_mesh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_RD) begin
            r_rdata <= r_mem[r_addr];
        end
        if (do_store) begin
            r_mem[r_count[ADDR_W-1:0]] <= r_key;
        end
    end

    always_comb begin
        n_state = r_state;
        n_addr  = r_addr;
        n_found = r_found;
        n_count = r_count;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_addr  = '0;
                    n_found = 1'b0;
                    n_state = (r_count == '0) ? S_RES : S_RD;
                end
            end
            S_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (r_rdata == r_key) begin
                    n_found = 1'b1;
                    n_state = S_RES;
                end else if (addr_next == r_count) begin
                    n_state = S_RES;
                end else begin
                    n_addr  = r_addr + ADDR_W'(1);
                    n_state = S_RD;
                end
            end
            S_RES: begin
                n_count = r_last ? '0 : count_after;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign busy           = (r_state != S_IDLE);
    assign o_strobe       = (r_state == S_RES);
    assign o_is_new       = do_store;
    assign o_table_full   = !r_found && !room;
    assign o_unique_index = r_found ? IDX_OUT_W'(r_addr)
                          : (room ? IDX_OUT_W'(r_count) : '0);
    assign o_unique_count = CNT_OUT_W'(count_after);
    assign o_u_out        = r_key[63:32];
    assign o_v_out        = r_key[31:0];
    assign o_end_of_mesh  = r_last;

    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy) else $error("strobe while idle");
    a_new_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !(o_is_new && o_table_full)) else $error("new and full");
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH)) else $error("count overflow");
    a_last_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_end_of_mesh) |=> (r_count == '0)) else $error("no clear");

endmodule
